// ----- design/icc_pkg.sv -----
// Shared types and constants for the claim/complete interrupt controller.
// Depends on nothing; every other design file uses it by scoped names.

package icc_pkg;

	// Field widths
	localparam int unsigned OP_W     = 2;
	localparam int unsigned OFFSET_W = 27;
	localparam int unsigned SIZE_W   = 2;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned ID_W     = 5;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned PRIO_W   = 3;
	localparam int unsigned NSRC     = 32;
	localparam int unsigned PADDR_W  = 4;

	// Transaction kinds
	typedef enum logic [OP_W-1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_RAISE = 2'd2,
		OP_DROP  = 2'd3
	} op_t;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FAIL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_SERVE = 2'd2;

	// Configuration register indexes (byte address 4*index)
	typedef enum logic [1:0] {
		CFG_MAX_SOURCE_ID = 2'd0,
		CFG_ENABLE_MASK   = 2'd1,
		CFG_PRIORITY      = 2'd2,
		CFG_REGION_LENGTH = 2'd3
	} cfg_idx_t;

	// Register reset values
	localparam logic [ID_W-1:0]     MAX_SOURCE_ID_RST = 5'd31;
	localparam logic [DATA_W-1:0]   ENABLE_MASK_RST   = 32'hFFFF_FFFE;
	localparam logic [PRIO_W-1:0]   PRIORITY_RST      = 3'd1;
	localparam logic [OFFSET_W-1:0] REGION_LENGTH_RST = 27'h400_0000;

	// Device address map
	localparam logic [OFFSET_W-1:0] ADDR_PRIO_FIRST = 27'd4;
	localparam logic [OFFSET_W-1:0] ADDR_PRIO_LAST  = 27'd124;
	localparam logic [OFFSET_W-1:0] ADDR_PENDING    = 27'h000_1000;
	localparam logic [OFFSET_W-1:0] ADDR_ENABLE     = 27'h000_2000;
	localparam logic [OFFSET_W-1:0] ADDR_CLAIM      = 27'h020_0004;

	// Only 32-bit accesses are legal
	localparam logic [SIZE_W-1:0] SIZE_WORD = 2'd2;

	// Index of the highest set bit, 0 when none is set
	function automatic logic [ID_W-1:0] top_bit(input logic [NSRC-1:0] v);
		logic [ID_W-1:0] n;
		n = '0;
		for (int i = 0; i < NSRC; i++) begin
			if (v[i]) begin
				n = ID_W'(i);
			end
		end
		return n;
	endfunction

endpackage

// ----- design/icc_if.sv -----
// Valid/ready channel interfaces for request and response transactions.
// Depends on icc_pkg for field widths.

interface icc_req_if;
	logic                             valid;
	logic                             ready;
	logic [icc_pkg::OP_W-1:0]         op;
	logic [icc_pkg::OFFSET_W-1:0]     offset;
	logic [icc_pkg::SIZE_W-1:0]       size_log2;
	logic [icc_pkg::DATA_W-1:0]       write_data;
	logic [icc_pkg::ID_W-1:0]         source_id;

	modport source (output valid, op, offset, size_log2, write_data, source_id, input ready);
	modport sink   (input valid, op, offset, size_log2, write_data, source_id, output ready);
endinterface

interface icc_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [icc_pkg::DATA_W-1:0]       read_data;
	logic [icc_pkg::STATUS_W-1:0]     status;
	logic                             raise_irq;
	logic                             lower_irq;

	modport source (output valid, read_data, status, raise_irq, lower_irq, input ready);
	modport sink   (input valid, read_data, status, raise_irq, lower_irq, output ready);
endinterface

// ----- design/interrupt_controller_claim_complete_core.sv -----
// Latency: a result appears in the cycle after its request transaction is accepted.
// Throughput: one transaction per cycle while rsp.ready is high; the response register is reloaded in
// the same cycle it is taken. The claim path goes through a 32-bit priority encoder.
// Reset (arst_n low, asynchronous): pending and served masks clear, no response is
// held, and the configuration registers return to their documented reset values.
// Depends on icc_pkg and icc_if.

module interrupt_controller_claim_complete_core (
	input  logic                          clk,
	input  logic                          arst_n,
	icc_req_if.sink                       req,
	icc_rsp_if.source                     rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [icc_pkg::PADDR_W-1:0]   paddr,
	input  logic [icc_pkg::DATA_W-1:0]    pwdata,
	output logic [icc_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	// Configuration registers
	logic [icc_pkg::ID_W-1:0]     max_source_id_q;
	logic [icc_pkg::DATA_W-1:0]   enable_mask_q;
	logic [icc_pkg::PRIO_W-1:0]   priority_q;
	logic [icc_pkg::OFFSET_W-1:0] region_length_q;

	// Interrupt state
	logic [icc_pkg::NSRC-1:0]     pending_q;
	logic [icc_pkg::NSRC-1:0]     served_q;

	// Response register
	logic                         rsp_valid_s1;
	logic [icc_pkg::DATA_W-1:0]   read_data_s1;
	logic [icc_pkg::STATUS_W-1:0] status_s1;
	logic                         raise_s1;
	logic                         lower_s1;

	logic                         cfg_wr;
	icc_pkg::cfg_idx_t            cfg_idx;
	logic                         accept;
	icc_pkg::op_t                 op;
	logic                         bad_access;
	logic [icc_pkg::NSRC-1:0]     open_mask;
	logic [icc_pkg::NSRC-1:0]     pending_d;
	logic [icc_pkg::NSRC-1:0]     served_d;
	logic [icc_pkg::NSRC-1:0]     open_d;
	logic [icc_pkg::ID_W-1:0]     claim_id;
	logic                         complete_ok;
	logic [icc_pkg::DATA_W-1:0]   read_data_d;
	logic [icc_pkg::STATUS_W-1:0] status_d;
	logic                         raise_d;
	logic                         lower_d;

	// APB: writes complete in the access phase, no wait states
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = icc_pkg::cfg_idx_t'(paddr[icc_pkg::PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_source_id_q <= icc_pkg::MAX_SOURCE_ID_RST;
			enable_mask_q   <= icc_pkg::ENABLE_MASK_RST;
			priority_q      <= icc_pkg::PRIORITY_RST;
			region_length_q <= icc_pkg::REGION_LENGTH_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				icc_pkg::CFG_MAX_SOURCE_ID: max_source_id_q <= pwdata[icc_pkg::ID_W-1:0];
				icc_pkg::CFG_ENABLE_MASK:   enable_mask_q   <= pwdata;
				icc_pkg::CFG_PRIORITY:      priority_q      <= pwdata[icc_pkg::PRIO_W-1:0];
				icc_pkg::CFG_REGION_LENGTH: region_length_q <= pwdata[icc_pkg::OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	// Return the addressed register, zero-extended
	always_comb begin
		unique case (cfg_idx)
			icc_pkg::CFG_MAX_SOURCE_ID:
				prdata = icc_pkg::DATA_W'(max_source_id_q);
			icc_pkg::CFG_ENABLE_MASK:
				prdata = enable_mask_q;
			icc_pkg::CFG_PRIORITY:
				prdata = icc_pkg::DATA_W'(priority_q);
			icc_pkg::CFG_REGION_LENGTH:
				prdata = icc_pkg::DATA_W'(region_length_q);
			default:
				prdata = '0;
		endcase
	end

	// Take a new transaction whenever the response slot is free or being drained
	assign req.ready = !rsp_valid_s1 || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign op        = icc_pkg::op_t'(req.op);

	assign bad_access = (req.offset[1:0] != 2'b00) || (req.size_log2 != icc_pkg::SIZE_WORD) ||
		(req.offset > region_length_q);
	assign open_mask  = pending_q & ~served_q;
	assign claim_id   = icc_pkg::top_bit(open_mask);
	assign complete_ok = (req.offset == icc_pkg::ADDR_CLAIM) && (req.write_data != '0) &&
		(req.write_data <= icc_pkg::DATA_W'(max_source_id_q));

	// Work out next state and the response for the presented transaction
	always_comb begin
		pending_d   = pending_q;
		served_d    = served_q;
		read_data_d = '0;
		status_d    = icc_pkg::STATUS_OK;
		raise_d     = 1'b0;
		lower_d     = 1'b0;
		unique case (op)
			icc_pkg::OP_READ: begin
				if (bad_access) begin
					status_d = icc_pkg::STATUS_FAIL;
				end else if (req.offset >= icc_pkg::ADDR_PRIO_FIRST &&
						req.offset <= icc_pkg::ADDR_PRIO_LAST) begin
					read_data_d = icc_pkg::DATA_W'(priority_q);
				end else if (req.offset == icc_pkg::ADDR_PENDING) begin
					read_data_d = open_mask;
				end else if (req.offset == icc_pkg::ADDR_ENABLE) begin
					read_data_d = enable_mask_q;
				end else if (req.offset == icc_pkg::ADDR_CLAIM && open_mask != '0) begin
					served_d    = served_q | (icc_pkg::NSRC'(1) << claim_id);
					read_data_d = icc_pkg::DATA_W'(claim_id);
				end
			end
			icc_pkg::OP_WRITE: begin
				if (bad_access) begin
					status_d = icc_pkg::STATUS_FAIL;
				end else if (complete_ok) begin
					served_d = served_q &
						~(icc_pkg::NSRC'(1) << req.write_data[icc_pkg::ID_W-1:0]);
				end
			end
			icc_pkg::OP_RAISE: pending_d = pending_q | (icc_pkg::NSRC'(1) << req.source_id);
			icc_pkg::OP_DROP:  pending_d = pending_q & ~(icc_pkg::NSRC'(1) << req.source_id);
			default: ;
		endcase

		open_d = pending_d & ~served_d;

		// Drive the external line requests from the updated open set
		unique case (op)
			icc_pkg::OP_READ: begin
				if (!bad_access && req.offset == icc_pkg::ADDR_CLAIM && open_mask != '0) begin
					lower_d = (open_d == '0);
				end
			end
			icc_pkg::OP_WRITE: begin
				if (!bad_access && complete_ok) begin
					if (open_d == '0) begin
						lower_d = 1'b1;
					end else begin
						raise_d  = 1'b1;
						status_d = icc_pkg::STATUS_SERVE;
					end
				end
			end
			icc_pkg::OP_RAISE: raise_d = (open_d != '0);
			icc_pkg::OP_DROP:  lower_d = (open_d == '0);
			default: ;
		endcase
	end

	// Advance interrupt state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			served_q  <= '0;
		end else if (accept) begin
			pending_q <= pending_d;
			served_q  <= served_d;
		end
	end

	// Hold the response until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s1 <= 1'b0;
		end else if (accept) begin
			rsp_valid_s1 <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_data_s1 <= read_data_d;
			status_s1    <= status_d;
			raise_s1     <= raise_d;
			lower_s1     <= lower_d;
		end
	end

	assign rsp.valid     = rsp_valid_s1;
	assign rsp.read_data = read_data_s1;
	assign rsp.status    = status_s1;
	assign rsp.raise_irq = raise_s1;
	assign rsp.lower_irq = lower_s1;

endmodule

// ----- design/icc_checker.sv -----
// Port-level checks on the response channel of the interrupt controller core.
// Depends on icc_pkg; bound to interrupt_controller_claim_complete_core below.

module icc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [icc_pkg::DATA_W-1:0]    rsp_read_data,
	input logic [icc_pkg::STATUS_W-1:0]  rsp_status,
	input logic                          rsp_raise_irq,
	input logic                          rsp_lower_irq
);

	// Never ask to raise and lower the line in one transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_raise_irq && rsp_lower_irq))
		else $error("raise and lower requested together");

	// A failed access leaves no data and no line request
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == icc_pkg::STATUS_FAIL |->
			rsp_read_data == '0 && !rsp_raise_irq && !rsp_lower_irq)
		else $error("failed access carries data or line request");

	// Serve status only comes with a raise request, never with read data
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == icc_pkg::STATUS_SERVE |->
			rsp_raise_irq && rsp_read_data == '0)
		else $error("serve status without raise");

	// Status code is one of the three defined values
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_status != 2'd3)
		else $error("undefined status code");

	// A stalled response holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data) &&
			$stable(rsp_status) && $stable(rsp_raise_irq) && $stable(rsp_lower_irq))
		else $error("stalled response changed");

endmodule

bind interrupt_controller_claim_complete_core icc_checker u_icc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_read_data (rsp.read_data),
	.rsp_status    (rsp.status),
	.rsp_raise_irq (rsp.raise_irq),
	.rsp_lower_irq (rsp.lower_irq)
);
